// File: rtl/core/scar_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers of the stereo comb/allpass reverb.
package scar_pkg;

  localparam int SampleW = 24;
  localparam int CoefW   = 16;
  localparam int MulBW   = CoefW + 2;
  localparam int ProdW   = SampleW + MulBW;
  localparam int AccW    = ProdW + 1;
  localparam int RndW    = AccW - CoefW;
  localparam int SumW    = SampleW + 2;

  localparam int NumComb      = 4;
  localparam int NumAp        = 2;
  localparam int NumCombLines = 2 * NumComb;
  localparam int NumApLines   = 2 * NumAp;
  localparam int CombLineW    = $clog2(NumCombLines);
  localparam int ApLineW      = $clog2(NumApLines);
  localparam int IdxW         = $clog2(NumComb);

  localparam int CombDepth = 2048;
  localparam int ApDepth   = 1024;
  localparam int CombPtrW  = $clog2(CombDepth);
  localparam int ApPtrW    = $clog2(ApDepth);
  localparam int CombAddrW = CombLineW + CombPtrW;
  localparam int ApAddrW   = ApLineW + ApPtrW;

  localparam int CombLenTab [NumCombLines] = '{1215, 1293, 1397, 1473, 1238, 1316, 1420, 1496};
  localparam int ApLenTab [NumApLines] = '{225, 556, 248, 579};

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegCombFeedback = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDamping      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAllpassGain  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCrossMix     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDryGain      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWetGain      = 3'd5;

  localparam logic [CoefW-1:0] CombFeedbackRst = 16'd51773;
  localparam logic [CoefW-1:0] DampingRst      = 16'd15729;
  localparam logic [CoefW-1:0] AllpassGainRst  = 16'd34079;
  localparam logic [CoefW-1:0] CrossMixRst     = 16'd17039;
  localparam logic [CoefW-1:0] DryGainRst      = 16'd47186;
  localparam logic [CoefW-1:0] WetGainRst      = 16'd31457;

  localparam logic [CoefW:0] Unity = (CoefW + 1)'(2 ** CoefW);
  localparam logic signed [AccW-1:0] RoundHalf = AccW'(2 ** (CoefW - 1));
  localparam logic signed [RndW-1:0] SatMax = RndW'(2 ** (SampleW - 1) - 1);
  localparam logic signed [RndW-1:0] SatMin = ~SatMax;
  localparam logic signed [SumW-1:0] AvgHalf = SumW'(2);

  typedef enum logic [4:0] {
    StIdle,
    StMix0,
    StMix1,
    StMix2,
    StCombRd,
    StCombP1,
    StCombP2,
    StCombDamp,
    StCombFb,
    StCombWr,
    StApRd,
    StApP,
    StApWr,
    StOutP1,
    StOutP2,
    StOutSum,
    StDone
  } state_e;

  function automatic logic [CombPtrW:0] comb_len(input logic [CombLineW-1:0] k);
    logic [CombPtrW:0] l;
    if (CombLenTab[k] < CombDepth) begin
      l = (CombPtrW + 1)'(CombLenTab[k]);
    end else begin
      l = (CombPtrW + 1)'(CombDepth);
    end
    return l;
  endfunction

  function automatic logic [ApPtrW:0] ap_len(input logic [ApLineW-1:0] k);
    logic [ApPtrW:0] l;
    if (ApLenTab[k] < ApDepth) begin
      l = (ApPtrW + 1)'(ApLenTab[k]);
    end else begin
      l = (ApPtrW + 1)'(ApDepth);
    end
    return l;
  endfunction

  // Division by the coefficient unity, rounding half toward plus infinity.
  function automatic logic signed [RndW-1:0] rnd_coef(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    t = v + RoundHalf;
    return t[AccW-1:CoefW];
  endfunction

  function automatic logic signed [RndW-1:0] ext_smp(input logic signed [SampleW-1:0] s);
    return {{(RndW - SampleW){s[SampleW-1]}}, s};
  endfunction

  function automatic logic sat_ovf(input logic signed [RndW-1:0] v);
    return (v > SatMax) || (v < SatMin);
  endfunction

  function automatic logic signed [SampleW-1:0] sat_smp(input logic signed [RndW-1:0] v);
    logic signed [SampleW-1:0] r;
    if (v > SatMax) begin
      r = SatMax[SampleW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[SampleW-1:0];
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/stereo_comb_allpass_reverb.sv
`timescale 1ns / 1ps
// Stereo reverb with four damped comb delays and two allpass delays per channel.
//
// A request on the input channel carries one stereo frame of signed Q1.23
// samples. The block takes one request at a time and answers it with one
// request on the output channel: both processed samples and a flag that is
// set when either of them was clamped to the sample range.
// All work runs through one shared multiplier followed by an accumulate
// register, under a sequencer that works through each channel in turn:
// cross mix, a read, damping, feedback and write for each comb line and a
// read, product and write for each allpass line, then the dry plus wet sum.
// The next input is taken only once the previous result has been loaded
// into the output register. The delay lines sit in two single-port memories
// with a registered read; a per-line wrap flag makes unwritten entries read
// as zero, so no clearing pass runs after reset.
// Reset loads the default coefficients and empties all delay lines. When
// the receiver stalls, the result waits in the output register; the next
// frame is still taken and computed, and it waits until that register frees.
// Coefficient writes are taken in any cycle and are meant for idle periods.
module stereo_comb_allpass_reverb (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [scar_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [scar_pkg::CoefW-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [scar_pkg::SampleW-1:0] dry_left_i,
  input  logic signed [scar_pkg::SampleW-1:0] dry_right_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [scar_pkg::SampleW-1:0] out_left_o,
  output logic signed [scar_pkg::SampleW-1:0] out_right_o,
  output logic                               saturated_o
);
  import scar_pkg::*;

  state_e state_q, state_d;

  logic [CoefW-1:0] comb_fb_q, damping_q, ap_gain_q, cross_mix_q, dry_gain_q, wet_gain_q;

  logic signed [SampleW-1:0] comb_mem [NumCombLines * CombDepth];
  logic signed [SampleW-1:0] ap_mem [NumApLines * ApDepth];
  logic signed [SampleW-1:0] comb_rd_q, ap_rd_q;

  logic [CombPtrW-1:0]       comb_ptr_q [NumCombLines];
  logic [NumCombLines-1:0]   comb_full_q;
  logic signed [SampleW-1:0] comb_damp_q [NumCombLines];
  logic [ApPtrW-1:0]         ap_ptr_q [NumApLines];
  logic [NumApLines-1:0]     ap_full_q;

  logic                      ch_q;
  logic [IdxW-1:0]           idx_q;
  logic signed [SampleW-1:0] dl_q, dr_q, in_q, wet_q, dly_q;
  logic signed [SumW-1:0]    sum_q;
  logic signed [ProdW-1:0]   prod_q, acc_q, prod_d;
  logic signed [SampleW-1:0] res_l_q, res_r_q, out_l_q, out_r_q;
  logic                      flag_q, out_sat_q, out_valid_q;

  logic [CombLineW-1:0]      comb_k;
  logic [ApLineW-1:0]        ap_k;
  logic [CombAddrW-1:0]      comb_addr;
  logic [ApAddrW-1:0]        ap_addr;
  logic signed [SampleW-1:0] comb_dly, ap_dly, own_smp, oth_smp;
  logic signed [SampleW-1:0] mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [AccW-1:0]    mac_sum, prod_ext;
  logic signed [RndW-1:0]    mac_rnd, prod_rnd;
  logic signed [SampleW-1:0] comb_wdata, ap_wdata, ap_out, mac_sat;
  logic signed [SumW-1:0]    avg_t;
  logic [CombPtrW:0]         comb_nxt, comb_l;
  logic [ApPtrW:0]           ap_nxt, ap_l;
  logic                      comb_we, ap_we, out_load, in_take;

  function automatic logic signed [MulBW-1:0] coef(input logic [CoefW-1:0] c);
    return {2'b00, c};
  endfunction

  function automatic logic signed [MulBW-1:0] one_minus(input logic [CoefW-1:0] c);
    logic [CoefW:0] t;
    t = Unity - {1'b0, c};
    return {1'b0, t};
  endfunction

  assign comb_k    = {ch_q, idx_q};
  assign ap_k      = {ch_q, idx_q[0]};
  assign comb_addr = {comb_k, comb_ptr_q[comb_k]};
  assign ap_addr   = {ap_k, ap_ptr_q[ap_k]};
  assign comb_dly  = comb_full_q[comb_k] ? comb_rd_q : '0;
  assign ap_dly    = ap_full_q[ap_k] ? ap_rd_q : '0;
  assign own_smp   = ch_q ? dr_q : dl_q;
  assign oth_smp   = ch_q ? dl_q : dr_q;

  assign prod_d     = mul_a * mul_b;
  assign mac_sum    = {acc_q[ProdW-1], acc_q} + {prod_q[ProdW-1], prod_q};
  assign prod_ext   = {prod_q[ProdW-1], prod_q};
  assign mac_rnd    = rnd_coef(mac_sum);
  assign prod_rnd   = rnd_coef(prod_ext);
  assign mac_sat    = sat_smp(mac_rnd);
  assign comb_wdata = sat_smp(ext_smp(in_q) + prod_rnd);
  assign ap_wdata   = sat_smp(ext_smp(wet_q) + prod_rnd);
  assign ap_out     = sat_smp(ext_smp(dly_q) - ext_smp(wet_q));
  assign avg_t      = sum_q + AvgHalf;

  assign comb_l   = comb_len(comb_k);
  assign ap_l     = ap_len(ap_k);
  assign comb_nxt = {1'b0, comb_ptr_q[comb_k]} + (CombPtrW + 1)'(1);
  assign ap_nxt   = {1'b0, ap_ptr_q[ap_k]} + (ApPtrW + 1)'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StMix0;
        end
      end
      StMix0:     state_d = StMix1;
      StMix1:     state_d = StMix2;
      StMix2:     state_d = StCombRd;
      StCombRd:   state_d = StCombP1;
      StCombP1:   state_d = StCombP2;
      StCombP2:   state_d = StCombDamp;
      StCombDamp: state_d = StCombFb;
      StCombFb:   state_d = StCombWr;
      StCombWr: begin
        state_d = (idx_q == IdxW'(NumComb - 1)) ? StApRd : StCombRd;
      end
      StApRd: state_d = StApP;
      StApP:  state_d = StApWr;
      StApWr: begin
        state_d = idx_q[0] ? StOutP1 : StApRd;
      end
      StOutP1: state_d = StOutP2;
      StOutP2: state_d = StOutSum;
      StOutSum: begin
        state_d = ch_q ? StDone : StMix0;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    comb_we  = 1'b0;
    ap_we    = 1'b0;
    out_load = 1'b0;
    in_take  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_take = 1'b1;
      end
      StMix0: begin
        mul_a = own_smp;
        mul_b = one_minus(cross_mix_q);
      end
      StMix1: begin
        mul_a = oth_smp;
        mul_b = coef(cross_mix_q);
      end
      StCombP1: begin
        mul_a = comb_dly;
        mul_b = one_minus(damping_q);
      end
      StCombP2: begin
        mul_a = comb_damp_q[comb_k];
        mul_b = coef(damping_q);
      end
      StCombFb: begin
        mul_a = comb_damp_q[comb_k];
        mul_b = coef(comb_fb_q);
      end
      StCombWr: begin
        comb_we = 1'b1;
      end
      StApP: begin
        mul_a = ap_dly;
        mul_b = coef(ap_gain_q);
      end
      StApWr: begin
        ap_we = 1'b1;
      end
      StOutP1: begin
        mul_a = own_smp;
        mul_b = coef(dry_gain_q);
      end
      StOutP2: begin
        mul_a = wet_q;
        mul_b = coef(wet_gain_q);
      end
      StDone: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign in_ready_o = in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comb_fb_q   <= CombFeedbackRst;
      damping_q   <= DampingRst;
      ap_gain_q   <= AllpassGainRst;
      cross_mix_q <= CrossMixRst;
      dry_gain_q  <= DryGainRst;
      wet_gain_q  <= WetGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCombFeedback: comb_fb_q   <= cfg_wdata_i;
        RegDamping:      damping_q   <= cfg_wdata_i;
        RegAllpassGain:  ap_gain_q   <= cfg_wdata_i;
        RegCrossMix:     cross_mix_q <= cfg_wdata_i;
        RegDryGain:      dry_gain_q  <= cfg_wdata_i;
        RegWetGain:      wet_gain_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ch_q        <= 1'b0;
      idx_q       <= '0;
      comb_full_q <= '0;
      ap_full_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumCombLines; i++) begin
        comb_ptr_q[i]  <= '0;
        comb_damp_q[i] <= '0;
      end
      for (int i = 0; i < NumApLines; i++) begin
        ap_ptr_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_take && in_valid_i) begin
        ch_q <= 1'b0;
      end
      if (state_q == StMix2) begin
        idx_q <= '0;
      end
      if (state_q == StCombDamp) begin
        comb_damp_q[comb_k] <= mac_sat;
      end
      if (comb_we) begin
        idx_q <= idx_q + IdxW'(1);
        if (comb_nxt >= comb_l) begin
          comb_ptr_q[comb_k]  <= '0;
          comb_full_q[comb_k] <= 1'b1;
        end else begin
          comb_ptr_q[comb_k] <= comb_nxt[CombPtrW-1:0];
        end
      end
      if (ap_we) begin
        idx_q <= idx_q + IdxW'(1);
        if (ap_nxt >= ap_l) begin
          ap_ptr_q[ap_k]  <= '0;
          ap_full_q[ap_k] <= 1'b1;
        end else begin
          ap_ptr_q[ap_k] <= ap_nxt[ApPtrW-1:0];
        end
      end
      if (state_q == StOutSum) begin
        ch_q <= ~ch_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= prod_q;
    if (in_take && in_valid_i) begin
      dl_q   <= dry_left_i;
      dr_q   <= dry_right_i;
      flag_q <= 1'b0;
    end
    if (state_q == StMix2) begin
      in_q  <= mac_sat;
      sum_q <= '0;
    end
    if (state_q == StCombP1) begin
      sum_q <= sum_q + {{(SumW - SampleW){comb_dly[SampleW-1]}}, comb_dly};
    end
    if (comb_we && (idx_q == IdxW'(NumComb - 1))) begin
      wet_q <= avg_t[SumW-1:2];
    end
    if (state_q == StApP) begin
      dly_q <= ap_dly;
    end
    if (ap_we) begin
      wet_q <= ap_out;
    end
    if (state_q == StOutSum) begin
      if (ch_q) begin
        res_r_q <= mac_sat;
      end else begin
        res_l_q <= mac_sat;
      end
      flag_q <= flag_q | sat_ovf(mac_rnd);
    end
    if (out_load) begin
      out_l_q   <= res_l_q;
      out_r_q   <= res_r_q;
      out_sat_q <= flag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (comb_we) begin
      comb_mem[comb_addr] <= comb_wdata;
    end
    comb_rd_q <= comb_mem[comb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ap_we) begin
      ap_mem[ap_addr] <= ap_wdata;
    end
    ap_rd_q <= ap_mem[ap_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_l_q;
  assign out_right_o = out_r_q;
  assign saturated_o = out_sat_q;

endmodule
